// File: rtl/rrt_pkg.sv
// rrt_pkg: shared types and constants for the reorder receive tracker
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package rrt_pkg;

  // fixed field widths
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned BYTES_W   = 25;
  localparam int unsigned OUT_CNT_W = 10;

  // bitmap row geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OFF_W     = $clog2(WORD_BITS);

  // operation codes
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_CLEARED   = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    rd_item;
    logic    rd_scan;
    logic    commit;
    logic    scan_step;
    logic    load_out;
    status_e status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic in_range;
    logic dup_bit;
    logic exp_in_window;
    logic word_full;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/rrt_ctrl.sv
// rrt_ctrl: sequencing state machine of the reorder receive tracker
// depends on rrt_pkg for the command, status and status code types
`default_nettype none

module rrt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rrt_pkg::sts_t sts_i,
  output rrt_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  rrt_pkg::status_e st_q, st_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    cmd_o          = '0;
    cmd_o.status   = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_clear) begin
          cmd_o.clear = 1'b1;
          st_d        = rrt_pkg::ST_CLEARED;
          state_d     = S_DONE;
        end else if (!sts_i.in_range) begin
          st_d    = rrt_pkg::ST_RANGE;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_item = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts_i.dup_bit) begin
          st_d    = rrt_pkg::ST_DUPLICATE;
          state_d = S_DONE;
        end else begin
          cmd_o.commit = 1'b1;
          st_d         = rrt_pkg::ST_ACCEPTED;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.exp_in_window) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_SCAN_EVAL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_EVAL: begin
        cmd_o.scan_step = 1'b1;
        state_d         = sts_i.word_full ? S_SCAN_RD : S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= rrt_pkg::ST_ACCEPTED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rrt_dpath.sv
// rrt_dpath: bitmap memory, counters, gap scan and result register
// depends on rrt_pkg; driven by rrt_ctrl through cmd_t and sts_t
`default_nettype none

module rrt_dpath #(
  parameter int unsigned WINDOW       = 512,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rrt_pkg::cmd_t                   cmd_i,
  output rrt_pkg::sts_t                        sts_o,
  input  wire logic                            operation_i,
  input  wire logic [rrt_pkg::SEQ_W-1:0]       seq_num_i,
  input  wire logic [rrt_pkg::LEN_W-1:0]       packet_length_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic [rrt_pkg::OUT_CNT_W-1:0]        next_expected_o,
  output logic [rrt_pkg::BYTES_W-1:0]          bytes_received_o,
  output logic [rrt_pkg::OUT_CNT_W-1:0]        packets_held_o
);

  localparam int unsigned WB    = rrt_pkg::WORD_BITS;
  localparam int unsigned OW    = rrt_pkg::OFF_W;
  localparam int unsigned SW    = rrt_pkg::SEQ_W;
  localparam int unsigned BW    = rrt_pkg::BYTES_W;
  localparam int unsigned ROWS  = (WINDOW + WB - 1) / WB;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned EXP_W = $clog2(WINDOW + 2);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  // captured word
  logic          op_q;
  logic [SW-1:0] seq_q;
  logic [SW-1:0] len_q;

  // tracker state
  logic [EXP_W-1:0] exp_q;
  logic [CNT_W-1:0] held_q;
  logic [BW-1:0]    bytes_q;
  logic [ROWS-1:0]  row_vld_q;
  logic [WB-1:0]    mem [ROWS];

  // read port
  logic [WB-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [ROW_W-1:0] rd_row_q;

  // result register
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [EXP_W-1:0] out_exp_q;
  logic [CNT_W-1:0] out_held_q;
  logic [BW-1:0]    out_bytes_q;

  // item and scan addressing
  logic [SW-1:0]    idx;
  logic [SW-1:0]    eidx;
  logic [ROW_W-1:0] item_row;
  logic [ROW_W-1:0] scan_row;
  logic [ROW_W-1:0] rd_addr;
  logic [WB-1:0]    word;

  assign idx      = seq_q - SW'(1);
  assign eidx     = SW'(exp_q) - SW'(1);
  assign item_row = idx[OW +: ROW_W];
  assign scan_row = eidx[OW +: ROW_W];
  assign rd_addr  = cmd_i.rd_scan ? scan_row : item_row;
  assign word     = rd_vld_q ? rd_data_q : '0;

  // payload bytes, floored at zero, and saturating total
  logic [SW-1:0] pay;
  logic [BW:0]   sum;
  assign pay = (len_q > SW'(HEADER_BYTES)) ? (len_q - SW'(HEADER_BYTES)) : '0;
  assign sum = {1'b0, bytes_q} + (BW + 1)'(pay);

  // first missing bit in the scanned row, bits below the pointer forced set
  logic [WB-1:0] masked;
  logic [OW-1:0] fz;
  logic          full;
  logic [SW-1:0] row_base;
  logic [SW-1:0] exp_next;
  assign masked   = word | ~({WB{1'b1}} << eidx[OW-1:0]);
  assign full     = &masked;
  assign row_base = {eidx[SW-1:OW], {OW{1'b0}}};

  always_comb begin
    fz = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!masked[i]) fz = OW'(i);
    end
  end

  assign exp_next = full ? (row_base + SW'(WB + 1)) : (row_base + SW'(fz) + SW'(1));

  // status back to the controller
  assign sts_o.is_clear      = (op_q == rrt_pkg::OP_CLEAR);
  assign sts_o.in_range      = (seq_q != '0) && (seq_q <= SW'(WINDOW));
  assign sts_o.dup_bit       = word[idx[OW-1:0]];
  assign sts_o.exp_in_window = (SW'(exp_q) <= SW'(WINDOW));
  assign sts_o.word_full     = full;
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      seq_q <= seq_num_i;
      len_q <= packet_length_i;
    end
  end

  // bitmap memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_item || cmd_i.rd_scan) begin
      rd_data_q <= mem[rd_addr];
      rd_row_q  <= rd_addr;
    end
    if (cmd_i.commit) begin
      mem[rd_row_q] <= word | (WB'(1) << idx[OW-1:0]);
    end
  end

  // row valid bits, read alongside the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.rd_item || cmd_i.rd_scan) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (cmd_i.clear) begin
        row_vld_q <= '0;
      end else if (cmd_i.commit) begin
        row_vld_q[rd_row_q] <= 1'b1;
      end
    end
  end

  // counters and expected pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= EXP_W'(1);
      held_q  <= '0;
      bytes_q <= '0;
    end else if (cmd_i.clear) begin
      exp_q   <= EXP_W'(1);
      held_q  <= '0;
      bytes_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        held_q  <= held_q + CNT_W'(1);
        bytes_q <= sum[BW] ? {BW{1'b1}} : sum[BW-1:0];
      end
      if (cmd_i.scan_step) begin
        exp_q <= exp_next[EXP_W-1:0];
      end
    end
  end

  // result register, reloads while the previous word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q    <= cmd_i.status;
      out_exp_q   <= exp_q;
      out_held_q  <= held_q;
      out_bytes_q <= bytes_q;
    end
  end

  // results masked to the field widths
  logic [31:0] exp_ext;
  logic [31:0] held_ext;
  assign exp_ext  = 32'(out_exp_q);
  assign held_ext = 32'(out_held_q);

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign next_expected_o  = exp_ext[rrt_pkg::OUT_CNT_W-1:0];
  assign packets_held_o   = held_ext[rrt_pkg::OUT_CNT_W-1:0];
  assign bytes_received_o = out_bytes_q;

endmodule

`default_nettype wire

// File: rtl/reorder_receive_tracker.sv
// reorder_receive_tracker: top level joining the controller and the datapath
// depends on rrt_pkg, rrt_ctrl and rrt_dpath
//
// Usage: one input channel (in_valid_i/in_ready_o) carries a word of
// operation, seq_num and packet_length; one output channel
// (out_valid_o/out_ready_i) returns exactly one result word per input word:
// status, next_expected, bytes_received and packets_held.
// Words are handled one at a time. After acceptance the controller decodes the
// word; a clear or out-of-range word then loads the result register, a
// duplicate does so after one bitmap lookup, and an accepted packet after the
// lookup and commit and a gap scan of R 32-bit bitmap rows, read one at a time
// through the single read port (R is 1 in the usual in-order case; the scan stops
// without a read when the pointer has run past the window). The next word is
// taken in the cycle after the load; a stalled receiver holds back at most one
// word in flight, and when the result register is still full the controller waits.
// Reset clears the bitmap row valid bits, the counters and the expected
// pointer at once; no clearing pass is needed, and a clear word does the same.
`default_nettype none

module reorder_receive_tracker #(
  parameter int unsigned WINDOW       = 512,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            operation_i,
  input  wire logic [rrt_pkg::SEQ_W-1:0]       seq_num_i,
  input  wire logic [rrt_pkg::LEN_W-1:0]       packet_length_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic [rrt_pkg::OUT_CNT_W-1:0]        next_expected_o,
  output logic [rrt_pkg::BYTES_W-1:0]          bytes_received_o,
  output logic [rrt_pkg::OUT_CNT_W-1:0]        packets_held_o
);

  rrt_pkg::cmd_t cmd;
  rrt_pkg::sts_t sts;

  // sequencing
  rrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  rrt_dpath #(
    .WINDOW       (WINDOW),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .seq_num_i        (seq_num_i),
    .packet_length_i  (packet_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .next_expected_o  (next_expected_o),
    .bytes_received_o (bytes_received_o),
    .packets_held_o   (packets_held_o)
  );

endmodule

`default_nettype wire

// File: rtl/rrt_checker.sv
// rrt_checker: port-level assertions for the reorder receive tracker
// depends on rrt_pkg; bound to reorder_receive_tracker below
`default_nettype none

module rrt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [1:0]                      status_o,
  input wire logic [rrt_pkg::OUT_CNT_W-1:0]   next_expected_o,
  input wire logic [rrt_pkg::BYTES_W-1:0]     bytes_received_o,
  input wire logic [rrt_pkg::OUT_CNT_W-1:0]   packets_held_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(next_expected_o)
      && $stable(bytes_received_o) && $stable(packets_held_o))
    else $error("result changed while stalled");

  // one word in flight: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted back to back");

  // a cleared result shows the reset state
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rrt_pkg::ST_CLEARED) |->
      (next_expected_o == rrt_pkg::OUT_CNT_W'(1)) && (bytes_received_o == '0)
      && (packets_held_o == '0))
    else $error("clear result does not show cleared state");

endmodule

bind reorder_receive_tracker rrt_checker u_rrt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .next_expected_o  (next_expected_o),
  .bytes_received_o (bytes_received_o),
  .packets_held_o   (packets_held_o)
);

`default_nettype wire
